// ===== hw/rtl/lttb_pkg.sv =====
// Shared types and constants for the LTTB index selector.
// No dependencies; used by lttb_div and lttb_downsample_indices.
`timescale 1ns / 1ps
`default_nettype none

package lttb_pkg;

  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int INDEX_BITS      = 16;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 17;

  localparam logic [CFG_IDX_BITS-1:0]  REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0]  REG_THRESHOLD    = 2'd1;
  localparam logic [CFG_DATA_BITS-1:0] COUNT_RESET      = 17'h10000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_OUT_FIRST,
    ST_DIV,
    ST_DIVW,
    ST_BND1,
    ST_BND2,
    ST_CHECK,
    ST_SUM,
    ST_SUMW,
    ST_MDIV,
    ST_MDIVW,
    ST_YA,
    ST_YAW,
    ST_SCAN,
    ST_SCANW1,
    ST_SCANW2,
    ST_OUT_PICK,
    ST_OUT_LAST,
    ST_OUT_PT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lttb_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on lttb_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module lttb_div #(
  parameter int W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          dividend,
  input  logic [W-1:0]          divisor,
  output logic [W-1:0]          quotient,
  output logic [W-1:0]          remainder,
  output lttb_pkg::div_stat_t   stat
);
  import lttb_pkg::*;

  localparam int CNTW = $clog2(W + 1);

  logic [CNTW-1:0] cnt;
  logic            done;
  logic [W:0]      acc;
  logic [W-1:0]    quo;
  logic [W-1:0]    dvs;
  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            ge;

  always_comb begin
    shifted = {acc[W-1:0], quo[W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNTW'(W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNTW'(1);
      done <= (cnt == CNTW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      acc <= ge ? diff : shifted;
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = acc[W-1:0];
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== hw/rtl/lttb_downsample_indices.sv =====
// LTTB downsampler: receives samples one item at a time and strobes the kept indices.
// Busy is high while an item is being worked on. Outside pass-through mode and with
// a threshold of 3 or more, the first item of a set also runs the bucket step division
// on the shared divider, DW = SAMPLE_BITS+clog2(MAX_SAMPLES)+9 bits wide (41 at
// default). An item that completes a reference bucket sums that bucket, divides for
// the mean on the shared divider and scores the picked bucket, one sample memory read
// per cycle. Results appear as one-cycle strobes on index/last and must be taken when
// shown. The sample memory has one write and one read port and never needs clearing.
// Depends on lttb_pkg and lttb_div.
`timescale 1ns / 1ps
`default_nettype none

module lttb_downsample_indices #(
  parameter int MAX_SAMPLES = lttb_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = lttb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                strobe,
  output logic [lttb_pkg::INDEX_BITS-1:0]     index,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lttb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lttb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lttb_pkg::*;

  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = AW + 1;
  localparam int BW   = CW + 1;
  localparam int SUMW = SAMPLE_BITS + AW + 1;
  localparam int DW   = SUMW + 8;
  localparam int YW   = SAMPLE_BITS + 9;
  localparam int C1W  = AW + 3;
  localparam int DYW  = SAMPLE_BITS + 1;
  localparam int P1W  = C1W + DYW;
  localparam int AJW  = AW + 2;
  localparam int YDW  = SAMPLE_BITS + 10;
  localparam int P2W  = AJW + YDW;
  localparam int DFW  = AW + SAMPLE_BITS + 13;

  state_t state, state_next;

  logic [CFG_DATA_BITS-1:0] sample_count;
  logic [CFG_DATA_BITS-1:0] threshold;
  logic [CW-1:0]            seen;
  logic [CW-1:0]            bucket;
  logic [AW-1:0]            prev;
  logic                     sv;
  logic                     s1_vld;
  logic                     s2_vld;

  logic [AW-1:0]            cur_j;
  logic [CW-1:0]            q0;
  logic [CW-1:0]            r0;
  logic [CW-1:0]            d_reg;
  logic [CW-1:0]            rem;
  logic [BW-1:0]            b_lo;
  logic [BW-1:0]            b_hi;
  logic [BW-1:0]            b_end;
  logic [AW-1:0]            sum_addr;
  logic signed [SUMW-1:0]   sum;
  logic signed [YW-1:0]     y8;
  logic signed [SAMPLE_BITS-1:0] ya;
  logic signed [YDW-1:0]    yd;
  logic signed [C1W-1:0]    c1;
  logic [AW-1:0]            scan_addr;
  logic [AW-1:0]            s1_j;
  logic [AW-1:0]            s2_j;
  logic signed [P1W-1:0]    p1;
  logic signed [P2W-1:0]    p2;
  logic                     have;
  logic [DFW-1:0]           best;
  logic [AW-1:0]            best_j;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic [AW-1:0]            raddr;

  logic [CW-1:0]            n_eff;
  logic                     pt;
  logic                     t_ge3;
  logic [CW-1:0]            t_m2;
  logic                     accept;
  logic [AW-1:0]            j_in;
  logic                     end_set;
  logic [BW-1:0]            rend;
  logic [BW-1:0]            len;
  logic [BW-1:0]            x2;
  logic                     pick_due;
  logic                     sum_last;
  logic                     scan_last;
  logic [CW:0]              rem_sum;
  logic                     wrap;
  logic [BW-1:0]            b_next;
  logic [CW-1:0]            rem_next;
  logic                     step;
  logic [SUMW-1:0]          sum_mag;
  logic signed [DYW-1:0]    dy;
  logic signed [AJW-1:0]    aj;
  logic signed [DFW-1:0]    diff;
  logic [DFW-1:0]           mag;
  logic                     cfg_hit;

  logic                     div_start;
  logic [DW-1:0]            dvd;
  logic [DW-1:0]            dvs;
  logic [DW-1:0]            quo;
  logic [DW-1:0]            rmd;
  div_stat_t                dstat;
  logic [AW-1:0]            out_idx;

  lttb_div #(.W(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .quotient  (quo),
    .remainder (rmd),
    .stat      (dstat)
  );

  always_comb begin
    if (sample_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(sample_count) > 32'(MAX_SAMPLES)) begin
      n_eff = CW'(MAX_SAMPLES);
    end else begin
      n_eff = CW'(sample_count);
    end
    pt        = (threshold == '0) || (32'(threshold) >= 32'(n_eff));
    t_ge3     = threshold >= CFG_DATA_BITS'(3);
    t_m2      = CW'(threshold) - CW'(2);
    accept    = start && !busy;
    j_in      = (seen >= n_eff) ? '0 : AW'(seen);
    end_set   = (CW'(cur_j) == n_eff - CW'(1));
    rend      = (b_end > BW'(n_eff)) ? BW'(n_eff) : b_end;
    len       = rend - b_hi;
    x2        = b_hi + rend - BW'(1);
    pick_due  = t_ge3 && (bucket < t_m2) && (BW'(seen) == rend);
    sum_last  = (BW'(sum_addr) == rend - BW'(1));
    scan_last = (BW'(scan_addr) == b_hi - BW'(1));
    rem_sum   = {1'b0, rem} + {1'b0, r0};
    wrap      = rem_sum >= {1'b0, d_reg};
    b_next    = b_end + BW'(q0) + BW'(wrap);
    rem_next  = wrap ? CW'(rem_sum - {1'b0, d_reg}) : CW'(rem_sum);
    step      = (state == ST_BND1) || (state == ST_BND2) || (state == ST_OUT_PICK);
    sum_mag   = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
    dy        = DYW'(rdata) - DYW'(ya);
    aj        = $signed(AJW'(prev)) - $signed(AJW'(s1_j));
    diff      = (DFW'(p1) <<< 7) - DFW'(p2);
    mag       = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
    cfg_hit   = cfg_valid && cfg_ready &&
                ((cfg_index == REG_SAMPLE_COUNT) || (cfg_index == REG_THRESHOLD));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (pt) state_next = ST_OUT_PT;
        else if (cur_j == '0) state_next = ST_OUT_FIRST;
        else state_next = ST_CHECK;
      end
      ST_OUT_FIRST: state_next = t_ge3 ? ST_DIV : ST_CHECK;
      ST_DIV:       state_next = ST_DIVW;
      ST_DIVW:      if (dstat.done) state_next = ST_BND1;
      ST_BND1:      state_next = ST_BND2;
      ST_BND2:      state_next = ST_CHECK;
      ST_CHECK: begin
        if (pick_due) state_next = ST_SUM;
        else if (end_set) state_next = ST_OUT_LAST;
        else state_next = ST_DONE;
      end
      ST_SUM:       if (sum_last) state_next = ST_SUMW;
      ST_SUMW:      state_next = ST_MDIV;
      ST_MDIV:      state_next = ST_MDIVW;
      ST_MDIVW:     if (dstat.done) state_next = ST_YA;
      ST_YA:        state_next = ST_YAW;
      ST_YAW:       state_next = ST_SCAN;
      ST_SCAN:      if (scan_last) state_next = ST_SCANW1;
      ST_SCANW1:    state_next = ST_SCANW2;
      ST_SCANW2:    state_next = ST_OUT_PICK;
      ST_OUT_PICK:  state_next = end_set ? ST_OUT_LAST : ST_DONE;
      ST_OUT_LAST:  state_next = ST_DONE;
      ST_OUT_PT:    state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    strobe    = 1'b0;
    out_idx   = '0;
    last      = 1'b0;
    raddr     = sum_addr;
    div_start = 1'b0;
    dvd       = {sum_mag, 8'b0};
    dvs       = DW'(len);
    unique case (state)
      ST_OUT_FIRST: strobe = 1'b1;
      ST_OUT_PICK: begin
        strobe  = 1'b1;
        out_idx = best_j;
      end
      ST_OUT_LAST: begin
        strobe  = 1'b1;
        out_idx = AW'(n_eff - CW'(1));
        last    = 1'b1;
      end
      ST_OUT_PT: begin
        strobe  = 1'b1;
        out_idx = cur_j;
        last    = end_set;
      end
      ST_DIV: begin
        div_start = 1'b1;
        dvd       = DW'(n_eff - CW'(2));
        dvs       = DW'(t_m2);
      end
      ST_MDIV:      div_start = 1'b1;
      ST_YA:        raddr = prev;
      ST_SCAN:      raddr = scan_addr;
      default: ;
    endcase
  end

  // register writes restart the set, so they wait until no item is in flight or offered
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign index     = INDEX_BITS'(out_idx);

  always_ff @(posedge clk) begin
    if (accept) mem[j_in] <= sample;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= COUNT_RESET;
      threshold    <= '0;
      seen         <= '0;
      bucket       <= '0;
      prev         <= '0;
      sv           <= 1'b0;
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
    end else begin
      state  <= state_next;
      sv     <= (state == ST_SUM);
      s1_vld <= (state == ST_SCAN);
      s2_vld <= s1_vld;
      if (cfg_hit) begin
        if (cfg_index == REG_SAMPLE_COUNT) sample_count <= cfg_data;
        else threshold <= cfg_data;
        seen   <= '0;
        bucket <= '0;
        prev   <= '0;
      end
      if (accept) seen <= CW'(j_in) + CW'(1);
      if (state == ST_OUT_PICK) begin
        prev   <= best_j;
        bucket <= bucket + CW'(1);
      end
      if ((state == ST_DONE) && end_set) begin
        seen   <= '0;
        bucket <= '0;
        prev   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur_j <= j_in;
    if (state == ST_DIV) d_reg <= t_m2;
    if ((state == ST_DIVW) && dstat.done) begin
      q0    <= CW'(quo);
      r0    <= CW'(rmd);
      b_end <= BW'(1);
      rem   <= '0;
    end
    if (step) begin
      b_lo  <= b_hi;
      b_hi  <= b_end;
      b_end <= b_next;
      rem   <= rem_next;
    end
    if (state == ST_CHECK) begin
      sum      <= '0;
      sum_addr <= AW'(b_hi);
    end
    if (state == ST_SUM) sum_addr <= sum_addr + AW'(1);
    if (sv) sum <= sum + SUMW'(rdata);
    if ((state == ST_MDIVW) && dstat.done) begin
      y8 <= sum[SUMW-1] ? -YW'(quo) : YW'(quo);
    end
    if (state == ST_YAW) begin
      ya        <= rdata;
      yd        <= YDW'(y8) - (YDW'(rdata) <<< 8);
      c1        <= $signed(C1W'({prev, 1'b0})) - $signed(C1W'(x2));
      have      <= 1'b0;
      scan_addr <= AW'(b_lo);
    end
    if (state == ST_SCAN) begin
      scan_addr <= scan_addr + AW'(1);
      s1_j      <= scan_addr;
    end
    if (s1_vld) begin
      p1   <= P1W'(c1) * P1W'(dy);
      p2   <= P2W'(aj) * P2W'(yd);
      s2_j <= s1_j;
    end
    if (s2_vld && (!have || (mag > best))) begin
      have   <= 1'b1;
      best   <= mag;
      best_j <= s2_j;
    end
  end

  a_pick_in_bucket: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_PICK) |-> (BW'(best_j) >= b_lo) && (BW'(best_j) < b_hi))
    else $error("pick outside its bucket");

  a_pick_scanned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_PICK) |-> have)
    else $error("pick emitted before any candidate was scored");

  a_set_restart: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && end_set) |=> (seen == '0) && (bucket == '0) && (prev == '0))
    else $error("counters not cleared at end of set");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !dstat.busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for lttb_downsample_indices: directed table, then random data sets.
// Strobes are checked by an in-bench LTTB selector or typed rows. Depends on lttb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import lttb_pkg::*;

  localparam int MAXS = 65536;
  localparam int SETTLE = 400;

  typedef struct {
    logic [15:0] index;
    logic        last;
  } pick_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [16:0] value;
    bit          typed;
    logic [15:0] exp_index;
    logic        exp_last;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] sample = '0;
  logic strobe;
  logic [15:0] index;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  lttb_downsample_indices dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .strobe(strobe), .index(index), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  pick_t kept_q[$];
  int errors = 0;
  int items = 0;
  int results = 0;
  int phases = 0;

  longint ys[MAXS];
  int unsigned seen, bucket, prev_pick, m_count, m_thr;
  int idle_pct;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint bnd(longint k, longint n, longint t);
    return (k * (n - 2)) / (t - 2) + 1;
  endfunction

  function automatic int unsigned eff_n();
    if (m_count == 0) return 1;
    if (m_count > MAXS) return MAXS;
    return m_count;
  endfunction

  function automatic int unsigned best_in_bucket(longint k, longint n, longint t);
    longint lo, hi, rend, len, sum, x2, y8, a, ya, t1, t2, d, best;
    int unsigned p;
    bit have;
    lo = bnd(k, n, t);
    hi = bnd(k + 1, n, t);
    rend = bnd(k + 2, n, t);
    sum = 0;
    have = 0;
    best = 0;
    p = 32'(lo);
    if (rend > n) rend = n;
    len = rend - hi;
    if (len == 0) len = 1;
    for (longint j = hi; j < rend && j < MAXS; j++) sum += ys[j];
    x2 = hi + rend - 1;
    y8 = (sum * 256) / len;
    a = prev_pick;
    ya = ys[prev_pick % MAXS];
    for (longint j = lo; j < hi && j < MAXS; j++) begin
      t1 = (2 * a - x2) * ((ys[j] - ya) * 256);
      t2 = 2 * (a - j) * (y8 - 256 * ya);
      d = t1 - t2;
      if (d < 0) d = -d;
      if (!have || d > best) begin
        have = 1;
        best = d;
        p = 32'(j);
      end
    end
    return p;
  endfunction

  // Returns the picks one sample causes and advances the bench state.
  task automatic select_indices(input logic signed [15:0] y, output pick_t out[$]);
    int unsigned n, t, j, p;
    longint e;
    n = eff_n();
    t = m_thr;
    j = seen;
    out = {};
    if (j >= n) j = 0;
    ys[j % MAXS] = y;
    seen = j + 1;
    if (t == 0 || t >= n) begin
      out.push_back('{j[15:0], j == n - 1});
    end else begin
      if (j == 0) out.push_back('{16'd0, 1'b0});
      if (t >= 3 && bucket < t - 2) begin
        e = bnd(bucket + 2, n, t);
        if (e > n) e = n;
        if (seen == e) begin
          p = best_in_bucket(bucket, n, t);
          out.push_back('{p[15:0], 1'b0});
          prev_pick = p;
          bucket++;
        end
      end
      if (j == n - 1) begin
        p = n - 1;
        out.push_back('{p[15:0], 1'b1});
      end
    end
    if (seen >= n) begin
      seen = 0;
      bucket = 0;
      prev_pick = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      results++;
      if (kept_q.size() == 0) begin
        report($sformatf("unexpected index %0d last %0b", index, last));
      end else begin
        if (index !== kept_q[0].index || last !== kept_q[0].last)
          report($sformatf("got index %0d last %0b, want index %0d last %0b",
                           index, last, kept_q[0].index, kept_q[0].last));
        void'(kept_q.pop_front());
      end
    end
  end

  task automatic send(input logic signed [15:0] y, input bit typed = 0,
                      input logic [15:0] ti = '0, input logic tl = 0);
    pick_t out[$];
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample <= y;
    do @(posedge clk); while (busy);
    items++;
    select_indices(y, out);
    if (typed) kept_q.push_back('{ti, tl});
    else foreach (out[i]) kept_q.push_back(out[i]);
  endtask

  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    while (kept_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [16:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (r == REG_SAMPLE_COUNT) m_count = v;
    else m_thr = v;
    seen = 0;
    bucket = 0;
    prev_pick = 0;
  endtask

  function automatic logic signed [15:0] rand_y();
    case ($urandom_range(4))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return $signed(16'($urandom_range(200))) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  row_t dir_rows[] = '{
    '{0, 0, 0, 1, 16'd0, 1'b0},
    '{0, 0, 0, 0, 0, 0},
    '{1, REG_SAMPLE_COUNT, 17'd3, 0, 0, 0},
    '{0, 0, 0, 1, 16'd0, 1'b0},
    '{0, 0, 0, 1, 16'd1, 1'b0},
    '{0, 0, 0, 1, 16'd2, 1'b1},
    '{1, REG_THRESHOLD, 17'd2, 0, 0, 0},
    '{0, 0, 17'h07FFF, 1, 16'd0, 1'b0},
    '{0, 0, 17'h08000, 0, 0, 0},
    '{0, 0, 0, 1, 16'd2, 1'b1},
    '{1, REG_THRESHOLD, 17'd1, 0, 0, 0},
    '{0, 0, 0, 1, 16'd0, 1'b0},
    '{1, REG_SAMPLE_COUNT, 17'd0, 0, 0, 0},
    '{0, 0, 17'h08000, 0, 0, 0},
    '{1, REG_SAMPLE_COUNT, 17'd10, 0, 0, 0},
    '{1, REG_THRESHOLD, 17'd4, 0, 0, 0},
    '{0, 0, 17'h07FFF, 0, 0, 0}, '{0, 0, 17'h08000, 0, 0, 0},
    '{0, 0, 17'd5, 0, 0, 0}, '{0, 0, 17'd5, 0, 0, 0},
    '{0, 0, 17'h07FFF, 0, 0, 0}, '{0, 0, 17'h08000, 0, 0, 0},
    '{0, 0, 17'd0, 0, 0, 0}, '{0, 0, 17'd0, 0, 0, 0},
    '{0, 0, 17'd1, 0, 0, 0}, '{0, 0, 17'd1, 0, 0, 0}
  };

  initial begin
    int unsigned n, t, sets, feed;
    m_count = COUNT_RESET;
    m_thr = 0;
    seen = 0;
    bucket = 0;
    prev_pick = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      else send(dir_rows[i].value[15:0], dir_rows[i].typed,
                dir_rows[i].exp_index, dir_rows[i].exp_last);
    end

    while (items < 1250) begin
      case (phases % 4)
        0: idle_pct = 0;
        1: idle_pct = 85;
        2: idle_pct = 14;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(9))
        0: n = $urandom_range(3) == 0 ? 0 : (1 + $urandom_range(2));
        1: n = $urandom_range(1) ? 17'h1FFFF : 17'h10000;
        default: n = $urandom_range(3, 40);
      endcase
      case ($urandom_range(9))
        0: t = 0;
        1: t = $urandom_range(1, 3);
        2: t = n;
        3: t = n + 1;
        4: t = $urandom_range(1) ? 17'h10000 : 17'h1FFFF;
        default: t = (n > 4 && n <= 65536) ? $urandom_range(3, n - 1) : 3;
      endcase
      if ($urandom_range(1)) begin
        write_reg(REG_SAMPLE_COUNT, n[16:0]);
        write_reg(REG_THRESHOLD, t[16:0]);
      end else begin
        write_reg(REG_THRESHOLD, t[16:0]);
        write_reg(REG_SAMPLE_COUNT, n[16:0]);
      end
      n = eff_n();
      if (n > 64) begin
        feed = $urandom_range(5, 30);
      end else begin
        sets = $urandom_range(1, 4);
        feed = sets * n + ($urandom_range(3) == 0 ? $urandom_range(n - 1) : 0);
      end
      repeat (feed) send(rand_y());
      phases++;
    end

    drain();
    foreach (kept_q[i]) report($sformatf("index %0d never strobed", kept_q[i].index));
    $display("Ran %0d samples over %0d register settings, checked %0d strobed indices.",
             items, phases, results);
    if (errors == 0) $display("lttb_downsample_indices: match");
    else $display("lttb_downsample_indices: mismatch");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("lttb_downsample_indices: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/lttb_pkg.sv
hw/rtl/lttb_div.sv
hw/rtl/lttb_downsample_indices.sv
bench/tb_top.sv
